// ===== src/irbr_pkg.sv =====
`default_nettype none

package irbr_pkg;

  localparam int SMP_W      = 24;
  localparam int T_W        = 16;
  localparam int LEN_W      = 13;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 12;
  localparam int POS_W      = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = ACC_W + T_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LEN_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE     = 1'b1;

  // mode codes 2 and 3 both select Hermite
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 13'd4096;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  localparam logic [LEN_W-1:0] LIN_MIN_LEN  = 13'd2;
  localparam logic [LEN_W-1:0] HERM_MIN_LEN = 13'd4;

  localparam logic signed [ACC_W-1:0]  SAT_MAX  = 48'sd8388607;
  localparam logic signed [ACC_W-1:0]  SAT_MIN  = -48'sd8388608;
  localparam logic signed [PROD_W-1:0] RND_PROD = PROD_W'(1) <<< (T_W - 1);
  localparam logic signed [ACC_W-1:0]  RND_FIN  = ACC_W'(1) <<< T_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_IDX,
    ST_RD,
    ST_WAIT,
    ST_COEF,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    KIND_NEAR,
    KIND_LIN,
    KIND_HERM,
    KIND_SHORT
  } kind_t;

endpackage

`default_nettype wire

// ===== src/irbr_ram.sv =====
`default_nettype none

module irbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== src/interpolated_ring_buffer_read_core.sv =====
`default_nettype none

// Sample store read at a fractional position.
// Requests enter on start/busy: a request is taken at a clock edge with start high
// and busy low. A write request (in_operation = 0) stores in_write_sample at
// in_write_address when inside the store, gives no result and leaves busy low.
// A read request takes in_read_position (signed, FRACTION_BITS fraction bits),
// wraps it modulo the active length and returns nearest, linear or Hermite value.
// The result shows on out_read_sample/out_too_short for one cycle with out_valid;
// the receiver cannot stall, so there is no back pressure on this side.
// The remainder unit finds one quotient bit per cycle; the single-port sample RAM
// then gives one read per cycle, and one shared multiplier does the Horner steps,
// each through ST_MUL and then ST_ACC. busy drops in the cycle out_valid is shown,
// so the next request can be taken while the result is on the ports.
// Reset clears control and config (length 4096, Hermite); the sample store is
// not cleared and must be written before it is read.
// Config writes (cfg_valid/cfg_ready, always ready) must go in while the block
// is idle; the block itself does not enforce this.
module interpolated_ring_buffer_read_core #(
  parameter int STORE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_operation,
  input  logic        [irbr_pkg::ADDR_W-1:0]      in_write_address,
  input  logic signed [irbr_pkg::SMP_W-1:0]       in_write_sample,
  input  logic signed [irbr_pkg::POS_W-1:0]       in_read_position,
  output logic                                    out_valid,
  output logic signed [irbr_pkg::SMP_W-1:0]       out_read_sample,
  output logic                                    out_too_short,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [irbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [irbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import irbr_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int MAG_W = POS_W - FRACTION_BITS;
  localparam int CNT_W = $clog2(MAG_W + 1);
  localparam int FX_W  = POS_W + T_W;
  localparam logic [31:0] DEPTH32 = 32'(STORE_DEPTH);
  localparam logic [POS_W:0] ONE_P = 1;
  localparam logic [POS_W:0] HALF  = ONE_P << (FRACTION_BITS - 1);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt, kind_in;

  logic [LEN_W-1:0]  len_cfg_r;
  logic [MODE_W-1:0] mode_cfg_r;
  logic [LEN_W-1:0]  len_eff, len_r, len_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt, a_r, a_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [T_W-1:0]    t_r, t_nxt;
  logic [1:0]        rd_cnt_r, rd_cnt_nxt, rd_last_cnt, ridx_r, k_r, k_nxt;
  logic              rvalid_r;

  logic signed [SMP_W-1:0]  y_r [4];
  logic signed [ACC_W-1:0]  m_r, m_nxt;
  logic signed [PROD_W-1:0] p_r, prod, p_rnd;
  logic signed [T_W:0]      t_s;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_sample_r, out_sample_nxt;
  logic                    out_short_r, out_short_nxt;

  logic                 accept, wr_ok, ram_we;
  logic [AW-1:0]        ram_addr;
  logic [SMP_W-1:0]     ram_rdata;

  logic signed [POS_W:0] pos_x, ip;
  logic        [POS_W:0] absp, int_abs;
  logic        [FX_W-1:0] fx;
  logic        [MAG_W-1:0] near_mag, int_mag;
  logic        [T_W-1:0]  t_in;

  logic [LEN_W:0]   rtry, rsub;
  logic [LEN_W-1:0] rstep, base, prev_base, a_next;

  logic signed [ACC_W-1:0] y0e, y1e, y2e, y3e, c1, c2, c3, rs16, fsum, fval;

  assign busy      = state_r != ST_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_read_sample = out_sample_r;
  assign out_too_short   = out_short_r;

  // active length never exceeds the store
  assign len_eff = ({{(32-LEN_W){1'b0}}, len_cfg_r} > DEPTH32) ? LEN_W'(DEPTH32) : len_cfg_r;
  assign wr_ok   = {{(32-ADDR_W){1'b0}}, in_write_address} < DEPTH32;
  assign ram_we  = accept && (in_operation == OP_WRITE) && wr_ok;
  assign ram_addr = busy ? AW'(a_r) : AW'(in_write_address);

  irbr_ram #(
    .WIDTH(SMP_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_write_sample),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (mode_cfg_r == MODE_NEAREST) begin
      kind_in = (len_eff == '0) ? KIND_SHORT : KIND_NEAR;
    end else if (mode_cfg_r == MODE_LINEAR || len_eff < HERM_MIN_LEN) begin
      kind_in = (len_eff < LIN_MIN_LEN) ? KIND_SHORT : KIND_LIN;
    end else begin
      kind_in = KIND_HERM;
    end
  end

  // integer part magnitude (floor for interpolation, rounded for nearest)
  assign pos_x    = {in_read_position[POS_W-1], in_read_position};
  assign absp     = in_read_position[POS_W-1] ? -pos_x : pos_x;
  assign near_mag = MAG_W'((absp + HALF) >> FRACTION_BITS);
  assign ip       = pos_x >>> FRACTION_BITS;
  assign int_abs  = in_read_position[POS_W-1] ? -ip : ip;
  assign int_mag  = MAG_W'(int_abs);
  assign fx       = FX_W'(in_read_position[FRACTION_BITS-1:0]) << T_W;
  assign t_in     = T_W'(fx >> FRACTION_BITS);

  // one restoring remainder step
  assign rtry  = {rem_r, mag_r[MAG_W-1]};
  assign rsub  = rtry - {1'b0, len_r};
  assign rstep = (rtry >= {1'b0, len_r}) ? LEN_W'(rsub) : LEN_W'(rtry);

  assign base      = (neg_r && rem_r != '0) ? len_r - rem_r : rem_r;
  assign prev_base = (base == '0) ? len_r - LEN_W'(1) : base - LEN_W'(1);
  assign a_next    = (a_r + LEN_W'(1) == len_r) ? '0 : a_r + LEN_W'(1);

  always_comb begin
    unique case (kind_r)
      KIND_HERM: rd_last_cnt = 2'd3;
      KIND_LIN:  rd_last_cnt = 2'd1;
      default:   rd_last_cnt = 2'd0;
    endcase
  end

  assign y0e = ACC_W'(y_r[0]);
  assign y1e = ACC_W'(y_r[1]);
  assign y2e = ACC_W'(y_r[2]);
  assign y3e = ACC_W'(y_r[3]);
  assign c1  = y2e - y0e;
  assign c2  = (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e;
  assign c3  = (y3e - y0e) + ((y1e - y2e) <<< 1) + (y1e - y2e);

  assign t_s   = {1'b0, t_r};
  assign prod  = PROD_W'(m_r) * PROD_W'(t_s);
  assign p_rnd = (p_r + RND_PROD) >>> T_W;
  assign rs16  = $signed(p_rnd[ACC_W-1:0]);
  assign fsum  = m_r + RND_FIN;
  assign fval  = fsum >>> (T_W + 1);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    len_nxt        = len_r;
    rem_nxt        = rem_r;
    a_nxt          = a_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    t_nxt          = t_r;
    rd_cnt_nxt     = rd_cnt_r;
    k_nxt          = k_r;
    m_nxt          = m_r;
    out_valid_nxt  = 1'b0;
    out_sample_nxt = out_sample_r;
    out_short_nxt  = out_short_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_READ) begin
          kind_nxt = kind_in;
          len_nxt  = len_eff;
          neg_nxt  = in_read_position[POS_W-1];
          mag_nxt  = (kind_in == KIND_NEAR) ? near_mag : int_mag;
          rem_nxt  = '0;
          cnt_nxt  = CNT_W'(MAG_W);
          t_nxt    = t_in;
          if (kind_in == KIND_SHORT) begin
            m_nxt     = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        rem_nxt = rstep;
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        // Hermite starts one entry back, then all reads walk forward with wrap
        a_nxt      = (kind_r == KIND_HERM) ? prev_base : base;
        rd_cnt_nxt = '0;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        a_nxt      = a_next;
        rd_cnt_nxt = rd_cnt_r + 2'd1;
        if (rd_cnt_r == rd_last_cnt) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_COEF;
      end
      ST_COEF: begin
        k_nxt = '0;
        unique case (kind_r)
          KIND_HERM: begin
            m_nxt     = c3;
            state_nxt = ST_MUL;
          end
          KIND_LIN: begin
            m_nxt     = y1e - y0e;
            state_nxt = ST_MUL;
          end
          default: begin
            m_nxt     = y0e <<< (T_W + 1);
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (kind_r == KIND_LIN) begin
          m_nxt     = (y0e + rs16) <<< (T_W + 1);
          state_nxt = ST_FIN;
        end else begin
          k_nxt = k_r + 2'd1;
          unique case (k_r)
            2'd0: begin
              m_nxt     = $signed(p_r[ACC_W-1:0]) + (c2 <<< T_W);
              state_nxt = ST_MUL;
            end
            2'd1: begin
              m_nxt     = rs16 + (c1 <<< T_W);
              state_nxt = ST_MUL;
            end
            default: begin
              m_nxt     = rs16 + (y1e <<< (T_W + 1));
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_short_nxt = kind_r == KIND_SHORT;
        priority if (kind_r == KIND_SHORT) begin
          out_sample_nxt = '0;
        end else if (fval > SAT_MAX) begin
          out_sample_nxt = SAT_MAX[SMP_W-1:0];
        end else if (fval < SAT_MIN) begin
          out_sample_nxt = SAT_MIN[SMP_W-1:0];
        end else begin
          out_sample_nxt = fval[SMP_W-1:0];
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= state_r == ST_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r  <= LEN_RESET;
      mode_cfg_r <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUFFER_LENGTH: len_cfg_r  <= cfg_data;
        CFG_READ_MODE:     mode_cfg_r <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    len_r        <= len_nxt;
    rem_r        <= rem_nxt;
    a_r          <= a_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    cnt_r        <= cnt_nxt;
    t_r          <= t_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    k_r          <= k_nxt;
    m_r          <= m_nxt;
    p_r          <= prod;
    ridx_r       <= rd_cnt_r;
    out_sample_r <= out_sample_nxt;
    out_short_r  <= out_short_nxt;
    if (rvalid_r) begin
      y_r[ridx_r] <= ram_rdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/irbr_checker.sv =====
`default_nettype none

module irbr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_operation,
  input logic                              out_valid,
  input logic signed [irbr_pkg::SMP_W-1:0] out_read_sample,
  input logic                              out_too_short
);

  import irbr_pkg::*;

  // write requests complete in the cycle they are taken
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_WRITE |=> !busy)
    else $error("write request raised busy");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_READ |=> busy)
    else $error("read request did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a read in flight");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_short |-> out_read_sample == '0)
    else $error("too_short result with nonzero sample");

endmodule

bind interpolated_ring_buffer_read_core irbr_checker u_irbr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_read_sample(out_read_sample),
  .out_too_short  (out_too_short)
);

`default_nettype wire

// ===== tb/sv/tb_interpolated_ring_buffer_read_core.sv =====
`default_nettype none

module tb_interpolated_ring_buffer_read_core;
  import irbr_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int FRAC_BITS    = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 52;

  localparam logic [MODE_W-1:0] MODE_HERMITE     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HERMITE_ALT = 2'd3;

  localparam logic signed [SMP_W-1:0] FULL_POS = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] FULL_NEG = 24'sh800000;

  typedef struct {
    logic                    op;
    logic [ADDR_W-1:0]       addr;
    logic signed [SMP_W-1:0] smp;
    logic signed [POS_W-1:0] pos;
  } request_t;

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    too_short;
  } read_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = 1'b0;
  logic [ADDR_W-1:0] in_write_address = '0;
  logic signed [SMP_W-1:0] in_write_sample = '0;
  logic signed [POS_W-1:0] in_read_position = '0;
  logic out_valid;
  logic signed [SMP_W-1:0] out_read_sample;
  logic out_too_short;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [SMP_W-1:0] smp_mem [DEPTH];
  logic [LEN_W-1:0]        cur_len = LEN_RESET;
  logic [MODE_W-1:0]       cur_mode = MODE_RESET;

  // generator side: which entries will have been written by the time a read is taken
  bit cell_written [DEPTH];

  request_t     request_q [$];
  read_result_t read_results_q [$];

  request_t     drv_req;
  read_result_t mon_exp;
  int burst_left = 0;
  int gap_left = 0;
  int phase_n = 0;
  int fail_n = 0;
  int quiet_cycles = 0;

  interpolated_ring_buffer_read_core #(
    .STORE_DEPTH  (DEPTH),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_write_address(in_write_address),
    .in_write_sample (in_write_sample),
    .in_read_position(in_read_position),
    .out_valid       (out_valid),
    .out_read_sample (out_read_sample),
    .out_too_short   (out_too_short),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint round_half_up(input longint v, input int sh);
    longint w;
    w = v + (longint'(1) <<< (sh - 1));
    return w >>> sh;
  endfunction

  function automatic longint active_length();
    longint eff;
    eff = longint'(cur_len);
    if (eff > DEPTH) eff = DEPTH;
    return eff;
  endfunction

  // Picks the read kind and the store entries it taps; t is the Q16 fraction.
  function automatic void locate_taps(input logic signed [POS_W-1:0] pos, output kind_t kind,
                                      output int ix [4], output longint t);
    longint p, eff, span, w, r, half;
    int i1;
    p = longint'(pos);
    eff = active_length();
    ix = '{default: 0};
    t = 0;
    if (cur_mode == MODE_NEAREST)
      kind = (eff == 0) ? KIND_SHORT : KIND_NEAR;
    else if (cur_mode == MODE_LINEAR || eff < longint'(HERM_MIN_LEN))
      kind = (eff < longint'(LIN_MIN_LEN)) ? KIND_SHORT : KIND_LIN;
    else
      kind = KIND_HERM;
    if (kind == KIND_NEAR) begin
      // round half away from zero, then true modulo
      half = longint'(1) <<< (FRAC_BITS - 1);
      r = (p >= 0) ? (p + half) >>> FRAC_BITS : -((-p + half) >>> FRAC_BITS);
      r = r % eff;
      if (r < 0) r += eff;
      ix[0] = int'(r);
    end else if (kind != KIND_SHORT) begin
      span = eff <<< FRAC_BITS;
      w = p % span;
      if (w < 0) w += span;
      i1 = int'(w >>> FRAC_BITS);
      t = w & ((longint'(1) <<< FRAC_BITS) - 1);
      if (FRAC_BITS > 16) t = t >>> (FRAC_BITS - 16);
      else t = t <<< (16 - FRAC_BITS);
      if (kind == KIND_LIN) begin
        ix[0] = i1;
        ix[1] = (i1 + 1 < eff) ? i1 + 1 : 0;
      end else begin
        ix[0] = (i1 == 0) ? int'(eff - 1) : i1 - 1;
        ix[1] = i1;
        ix[2] = (i1 + 1 < eff) ? i1 + 1 : 0;
        ix[3] = (ix[2] + 1 < eff) ? ix[2] + 1 : 0;
      end
    end
  endfunction

  function automatic read_result_t interpolate_read(input logic signed [POS_W-1:0] pos);
    kind_t kind;
    int ix [4];
    longint t, v, c1, c2, c3, s;
    longint y [4];
    read_result_t res;
    locate_taps(pos, kind, ix, t);
    foreach (y[k]) y[k] = longint'(smp_mem[ix[k]]);
    v = 0;
    case (kind)
      KIND_NEAR: v = y[0];
      KIND_LIN: v = y[0] + round_half_up((y[1] - y[0]) * t, 16);
      KIND_HERM: begin
        // coefficients carry a factor of two, removed by the final shift
        c1 = y[2] - y[0];
        c2 = 2 * y[0] - 5 * y[1] + 4 * y[2] - y[3];
        c3 = (y[3] - y[0]) + 3 * (y[1] - y[2]);
        s = c3 * t + c2 * 65536;
        s = round_half_up(s * t, 16) + c1 * 65536;
        s = round_half_up(s * t, 16) + 2 * y[1] * 65536;
        v = round_half_up(s, 17);
      end
      default: v = 0;
    endcase
    if (v > SAT_MAX) v = longint'(SAT_MAX);
    if (v < SAT_MIN) v = longint'(SAT_MIN);
    res.sample = v[SMP_W-1:0];
    res.too_short = (kind == KIND_SHORT);
    return res;
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return FULL_POS;
      1: return FULL_NEG;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_position();
    longint eff, v;
    eff = active_length();
    if (eff == 0) eff = 1;
    case ($urandom_range(0, 5))
      0: v = longint'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 64'sh7FFFFFFF;
          1: v = -64'sh80000000;
          2: v = 0;
          default: v = -1;
        endcase
      end
      2: v = ((longint'($urandom_range(0, int'(8 * eff))) - 4 * eff) <<< FRAC_BITS)
             + $urandom_range(0, 65535);
      // exact half steps, both signs
      3: v = ((longint'($urandom_range(0, int'(8 * eff))) - 4 * eff) <<< FRAC_BITS) + 32768;
      // just around the wrap point, several spans away
      4: v = (((longint'($urandom_range(0, 6)) - 3) * eff
               + ($urandom_range(0, 1) ? eff - 1 : 0)) <<< FRAC_BITS)
             + $urandom_range(0, 65535);
      default: v = (longint'($urandom_range(0, int'(eff - 1))) <<< FRAC_BITS)
                   + $urandom_range(0, 65535);
    endcase
    return v[POS_W-1:0];
  endfunction

  task automatic queue_write(input int addr, input logic signed [SMP_W-1:0] smp);
    request_t r;
    r.op = OP_WRITE;
    r.addr = addr[ADDR_W-1:0];
    r.smp = smp;
    r.pos = $urandom;
    request_q.push_back(r);
    cell_written[addr] = 1'b1;
    phase_n++;
  endtask

  // Fills any entry the read taps that has not been written yet, then the read.
  task automatic queue_read(input logic signed [POS_W-1:0] pos);
    request_t r;
    kind_t kind;
    int ix [4];
    longint t;
    int n;
    locate_taps(pos, kind, ix, t);
    case (kind)
      KIND_NEAR: n = 1;
      KIND_LIN: n = 2;
      KIND_HERM: n = 4;
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++)
      if (!cell_written[ix[k]]) queue_write(ix[k], rand_sample());
    r.op = OP_READ;
    r.addr = ADDR_W'($urandom_range(0, DEPTH - 1));
    r.smp = SMP_W'($urandom);
    r.pos = pos;
    request_q.push_back(r);
    phase_n++;
  endtask

  task automatic queue_random_item();
    longint eff;
    eff = active_length();
    if ($urandom_range(0, 9) < 3) begin
      if (eff > 0 && $urandom_range(0, 1))
        queue_write($urandom_range(0, int'(eff - 1)), rand_sample());
      else
        queue_write($urandom_range(0, DEPTH - 1), rand_sample());
    end else begin
      queue_read(rand_position());
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || read_results_q.size() != 0 || start)
      @(posedge clk);
    // writes leave no result; give the block time to settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int len, input logic [MODE_W-1:0] mode);
    cfg_index <= CFG_BUFFER_LENGTH;
    cfg_data  <= len[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_len = len[LEN_W-1:0];
    cfg_index <= CFG_READ_MODE;
    cfg_data  <= {(CFG_DATA_W - MODE_W)'($urandom), mode};
    do @(posedge clk); while (!cfg_ready);
    cur_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int len, input logic [MODE_W-1:0] mode, input int budget);
    wait_drained();
    set_config(len, mode);
    phase_n = 0;
    while (phase_n < budget) queue_random_item();
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        drv_req = request_q.pop_front();
        if (drv_req.op == OP_READ) read_results_q.push_back(interpolate_read(drv_req.pos));
        else smp_mem[drv_req.addr] = drv_req.smp;
      end
      if (start && busy) begin
        // request still waiting, keep it on the ports
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() != 0) begin
        start            <= 1'b1;
        in_operation     <= request_q[0].op;
        in_write_address <= request_q[0].addr;
        in_write_sample  <= request_q[0].smp;
        in_read_position <= request_q[0].pos;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (read_results_q.size() == 0) begin
        $error("unexpected result: read_sample %0d too_short %0b", out_read_sample,
               out_too_short);
        fail_n++;
      end else begin
        mon_exp = read_results_q.pop_front();
        if (out_read_sample !== mon_exp.sample) begin
          $error("read_sample: expected %0d, actual %0d", mon_exp.sample, out_read_sample);
          fail_n++;
        end
        if (out_too_short !== mon_exp.too_short) begin
          $error("too_short: expected %0b, actual %0b", mon_exp.too_short, out_too_short);
          fail_n++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: full length, Hermite; overshoot past full scale both ways
    queue_write(10, FULL_NEG);
    queue_write(11, FULL_POS);
    queue_write(12, FULL_POS);
    queue_write(13, FULL_NEG);
    queue_write(20, FULL_POS);
    queue_write(21, FULL_NEG);
    queue_write(22, FULL_NEG);
    queue_write(23, FULL_POS);
    queue_read(32'sh000B8000);
    queue_read(32'sh00158000);
    // wrap at both ends of the position range
    queue_read(32'sh00000000);
    queue_read(-32'sd1);
    queue_read(32'sh7FFFFFFF);
    queue_read(32'sh80000000);

    // length above depth, nearest: halves round away from zero
    wait_drained();
    set_config(8191, MODE_NEAREST);
    queue_read(32'sh00008000);
    queue_read(-32'sh8000);
    queue_read(32'sh00017FFF);
    queue_read(32'sh7FFFFFFF);

    run_phase(4096, MODE_LINEAR, PHASE_ITEMS);
    run_phase(0, MODE_NEAREST, 20);
    run_phase(0, MODE_LINEAR, 20);
    run_phase(1, MODE_HERMITE, 20);
    run_phase(1, MODE_NEAREST, PHASE_ITEMS);
    run_phase(2, MODE_HERMITE, PHASE_ITEMS);
    run_phase(3, MODE_HERMITE_ALT, PHASE_ITEMS);
    run_phase(4, MODE_HERMITE, PHASE_ITEMS);
    run_phase(5, MODE_NEAREST, PHASE_ITEMS);
    run_phase(7, MODE_LINEAR, PHASE_ITEMS);
    run_phase(16, MODE_HERMITE_ALT, PHASE_ITEMS);
    run_phase(100, MODE_HERMITE, PHASE_ITEMS);
    run_phase(4097, MODE_LINEAR, PHASE_ITEMS);
    run_phase(8191, MODE_HERMITE, PHASE_ITEMS);
    run_phase(4096, MODE_NEAREST, PHASE_ITEMS);
    repeat (6) run_phase($urandom_range(4, 64), MODE_W'($urandom_range(0, 3)), PHASE_ITEMS);
    run_phase(4096, MODE_HERMITE, PHASE_ITEMS);

    wait_drained();
    if (fail_n == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/irbr_pkg.sv
src/irbr_ram.sv
src/interpolated_ring_buffer_read_core.sv
src/irbr_checker.sv
tb/sv/tb_interpolated_ring_buffer_read_core.sv
